/* rtl/ehm_pkg.sv */
// ----------------------------------------------------------------------------
// ehm_pkg: shared types and helpers of the elapsed hour meter
// Holds the transfer payload types, the register indexes and the
// seven-segment lookup.
// ----------------------------------------------------------------------------
package ehm_pkg;

	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth  = 8;

	localparam logic [CfgIndexWidth-1:0] REG_PRESET_SECONDS  = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_PRESET_MINUTES  = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_PRESET_QUARTERS = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_PRESET_HOURS    = 3'd3;
	localparam logic [CfgIndexWidth-1:0] REG_PRESET_HUNDREDS = 3'd4;
	localparam logic [CfgIndexWidth-1:0] REG_DISPLAY_SECONDS = 3'd5;

	localparam logic [5:0] SecondsMax = 6'd59;
	localparam logic [5:0] MinutesMax = 6'd59;
	localparam logic [6:0] HoursMax   = 7'd99;
	localparam logic [2:0] DisplayTicksReset = 3'd7;

	localparam logic [2:0] QuarterNone  = 3'd0;
	localparam logic [2:0] QuarterOne   = 3'd4;
	localparam logic [2:0] QuarterTwo   = 3'd6;
	localparam logic [2:0] QuarterThree = 3'd7;

	typedef struct packed {
		logic clear_button;
		logic power_fail;
	} in_t;

	typedef struct packed {
		logic [7:0] left_segments;
		logic [7:0] right_segments;
		logic [7:0] pile_segments;
		logic       display_on;
		logic       heartbeat_blink;
		logic       ack_flash;
		logic       save_request;
		logic [5:0] seconds_now;
		logic [5:0] minutes_now;
		logic [2:0] quarter_now;
		logic [6:0] hours_now;
		logic [7:0] hundreds_now;
	} out_t;

	// active-high segment pattern a..g, dp of one decimal digit
	function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
		logic [7:0] pat;
		case (digit)
			4'd0:    pat = 8'b1111_1100;
			4'd1:    pat = 8'b0110_0000;
			4'd2:    pat = 8'b1101_1010;
			4'd3:    pat = 8'b1111_0010;
			4'd4:    pat = 8'b0110_0110;
			4'd5:    pat = 8'b1011_0110;
			4'd6:    pat = 8'b1011_1110;
			4'd7:    pat = 8'b1110_0000;
			4'd8:    pat = 8'b1111_1110;
			4'd9:    pat = 8'b1111_0110;
			default: pat = 8'b0000_0000;
		endcase
		return pat;
	endfunction

	// tens digit of a value below 100: multiply by reciprocal of ten
	function automatic logic [3:0] tens_digit(input logic [6:0] value);
		logic [14:0] prod;
		prod = 15'(value) * 15'd205;
		return prod[14:11];
	endfunction

endpackage

/* rtl/elapsed_hour_meter.sv */
// ----------------------------------------------------------------------------
// elapsed_hour_meter: elapsed-time hour meter with seven-segment results
// One input transfer per one-second tick advances the cascaded time
// counters and yields one display/status result.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+----------------
//  input   | in_valid, in_ready, in_data      | in        | ehm_pkg::in_t
//  result  | out_valid, out_ready, out_data   | out       | ehm_pkg::out_t
//  config  | cfg_we, cfg_index, cfg_data      | in        | 8-bit write
//
//  The counter update and the display decode are combinational and sit
//  between the counter registers and the result register.
//  A new tick is taken every cycle while the result register is empty or
//  being drained in the same cycle; a stalled result holds the input off.
//  Reset clears the counters to zero, loads the display countdown with 7,
//  clears the halt flag and empties the result register.
//  After a tick with power_fail the block freezes: later ticks still get a
//  result, showing the frozen counters with no save, ack or heartbeat flags.
//
module elapsed_hour_meter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  ehm_pkg::in_t                         in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output ehm_pkg::out_t                        out_data,
	input  logic                                 cfg_we,
	input  logic [ehm_pkg::CfgIndexWidth-1:0]    cfg_index,
	input  logic [ehm_pkg::CfgDataWidth-1:0]     cfg_data
);
	import ehm_pkg::*;

	// counter state
	logic [5:0] sec_q;
	logic [5:0] min_q;
	logic [2:0] qtr_q;
	logic [6:0] hour_q;
	logic [7:0] hund_q;
	logic [2:0] cdown_q;
	logic       halted_q;

	// result register
	logic       out_valid_q;
	out_t       out_q;

	// next-state values of this tick
	logic [5:0] sec_n;
	logic [5:0] min_n;
	logic [2:0] qtr_n;
	logic [6:0] hour_n;
	logic [7:0] hund_n;
	logic [2:0] cdown_n;
	logic       save;
	logic       clr;
	logic [5:0] snap_sec;
	logic [5:0] snap_min;
	logic [2:0] snap_qtr;
	logic [6:0] snap_hour;
	logic [7:0] snap_hund;
	logic [3:0] tens;
	logic [3:0] units;
	logic [7:0] tens_x10;
	out_t       res;
	logic       accept;

	// advance only when the result register is free or drains this cycle
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		clr    = in_data.clear_button && !halted_q;
		save   = in_data.power_fail && !halted_q;
		sec_n  = sec_q;
		min_n  = min_q;
		qtr_n  = qtr_q;
		hour_n = hour_q;
		hund_n = hund_q;
		if (!halted_q) begin
			sec_n = sec_q + 6'd1;
			if (clr) begin
				sec_n  = '0;
				min_n  = '0;
				qtr_n  = QuarterNone;
				hour_n = '0;
				hund_n = '0;
			end
		end
		// snapshot for the save request, before the carry cascade
		snap_sec  = sec_n;
		snap_min  = min_n;
		snap_qtr  = qtr_n;
		snap_hour = hour_n;
		snap_hund = hund_n;
		if (sec_n > SecondsMax) begin
			sec_n = '0;
			min_n = min_n + 6'd1;
			if (min_n >= 6'd45) begin
				qtr_n = QuarterThree;
			end else if (min_n >= 6'd30) begin
				qtr_n = QuarterTwo;
			end else if (min_n >= 6'd15) begin
				qtr_n = QuarterOne;
			end else begin
				qtr_n = QuarterNone;
			end
			// the quarter code stays 7 across the hour rollover
			if (min_n > MinutesMax) begin
				min_n  = '0;
				hour_n = hour_n + 7'd1;
				if (hour_n > HoursMax) begin
					hour_n = '0;
					hund_n = hund_n + 8'd1;
				end
			end
		end

		// hold the countdown while frozen or already at zero
		cdown_n = cdown_q;
		if (!halted_q && cdown_q != 3'd0) begin
			cdown_n = cdown_q - 3'd1;
		end

		tens     = tens_digit(hour_n);
		tens_x10 = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
		units    = 4'(8'(hour_n) - tens_x10);

		res.left_segments   = ~seg_pattern(tens);
		res.right_segments  = ~seg_pattern(units);
		res.pile_segments   = ~{qtr_n, hund_n[3:0], 1'b0};
		res.display_on      = cdown_q != 3'd0;
		res.heartbeat_blink = !halted_q && cdown_q == 3'd0;
		res.ack_flash       = clr || save;
		res.save_request    = save;
		if (save) begin
			res.seconds_now  = snap_sec;
			res.minutes_now  = snap_min;
			res.quarter_now  = snap_qtr;
			res.hours_now    = snap_hour;
			res.hundreds_now = snap_hund;
		end else begin
			res.seconds_now  = sec_n;
			res.minutes_now  = min_n;
			res.quarter_now  = qtr_n;
			res.hours_now    = hour_n;
			res.hundreds_now = hund_n;
		end
	end

	// counters: a register write restores a counter, a tick advances them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q    <= '0;
			min_q    <= '0;
			qtr_q    <= QuarterNone;
			hour_q   <= '0;
			hund_q   <= '0;
			cdown_q  <= DisplayTicksReset;
			halted_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESET_SECONDS: begin
					sec_q <= (cfg_data[5:0] > SecondsMax) ? SecondsMax : cfg_data[5:0];
				end
				REG_PRESET_MINUTES: begin
					min_q <= (cfg_data[5:0] > MinutesMax) ? MinutesMax : cfg_data[5:0];
				end
				REG_PRESET_QUARTERS: qtr_q <= cfg_data[2:0];
				REG_PRESET_HOURS: begin
					hour_q <= (cfg_data[6:0] > HoursMax) ? HoursMax : cfg_data[6:0];
				end
				REG_PRESET_HUNDREDS: hund_q  <= cfg_data;
				REG_DISPLAY_SECONDS: cdown_q <= cfg_data[2:0];
				default: ;
			endcase
		end else if (accept) begin
			sec_q   <= sec_n;
			min_q   <= min_n;
			qtr_q   <= qtr_n;
			hour_q  <= hour_n;
			hund_q  <= hund_n;
			cdown_q <= cdown_n;
			if (save) begin
				halted_q <= 1'b1;
			end
		end
	end

	// result register: fill on an input transfer, drop on an output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

endmodule

/* rtl/ehm_checker.sv */
// ----------------------------------------------------------------------------
// ehm_checker: port-level checks of the elapsed hour meter
// Watches the top-level ports and flags results that break its rules.
// ----------------------------------------------------------------------------
module ehm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input ehm_pkg::out_t                     out_data
);
	import ehm_pkg::*;

	logic saw_save_q;

	// remember that a save result has been transferred; the block is frozen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saw_save_q <= 1'b0;
		end else if (out_valid && out_ready && out_data.save_request) begin
			saw_save_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow the result register");

	a_frozen_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saw_save_q |-> !out_data.save_request && !out_data.ack_flash)
		else $error("flags raised after the block froze");

	a_blink_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.display_on && out_data.heartbeat_blink)
		&& (!out_data.save_request || out_data.ack_flash))
		else $error("inconsistent status flags");

	a_hours_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.hours_now <= HoursMax
		&& out_data.minutes_now <= MinutesMax)
		else $error("hours or minutes out of range");

endmodule

bind elapsed_hour_meter ehm_checker u_ehm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
